// ===== rtl/core/sss_pkg.sv =====
// Shared types and constants for the sorted set store.
// Used by the cell, the controller, the top level and the checker.
package sss_pkg;

    localparam int CAPACITY  = 16;
    localparam int ELEM_BITS = 32;
    localparam int CNT_W     = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        MODE_ADD    = 2'd0,
        MODE_REMOVE = 2'd1,
        MODE_QUERY  = 2'd2,
        MODE_LIST   = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2,
        OP_ROTATE = 2'd3
    } t_cell_op;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [31:0] elem;
    } t_in_word;

    typedef struct packed {
        logic               was_member;
        logic [4:0]         count;
        logic               is_empty;
        logic signed [31:0] smallest;
        logic               status;
        logic signed [31:0] listed_value;
        logic               last;
    } t_out_word;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        t_cell_op                      op;
        logic signed [ELEM_BITS-1:0]   key;
    } t_cell_cmd;

    // Summary of the chain seen by the controller.
    typedef struct packed {
        logic                          member;
        logic signed [ELEM_BITS-1:0]   head;
    } t_chain_stat;

endpackage

// ===== rtl/core/sss_cell.sv =====
// One storage cell of the sorted chain: compares its element with the key
// and shifts toward either neighbor. Depends on sss_pkg.
module sss_cell
    import sss_pkg::*;
(
    input  logic                        i_clk,
    input  t_cell_cmd                   i_cmd,
    input  logic                        i_occ,
    input  logic                        i_tail,
    input  logic signed [ELEM_BITS-1:0] i_left,
    input  logic                        i_left_lt,
    input  logic signed [ELEM_BITS-1:0] i_right,
    input  logic signed [ELEM_BITS-1:0] i_head,
    output logic signed [ELEM_BITS-1:0] o_value,
    output logic                        o_lt,
    output logic                        o_eq
);

    logic signed [ELEM_BITS-1:0] r_value;
    logic signed [ELEM_BITS-1:0] n_value;

    assign o_lt    = i_occ && (r_value < i_cmd.key);
    assign o_eq    = i_occ && (r_value == i_cmd.key);
    assign o_value = r_value;

    always_comb begin
        n_value = r_value;
        case (i_cmd.op)
            OP_INSERT: begin
                // The first cell not below the key takes the key; the ones
                // after it take their left neighbor.
                if (!o_lt) begin
                    n_value = i_left_lt ? i_cmd.key : i_left;
                end
            end
            OP_REMOVE: begin
                if (!o_lt) begin
                    n_value = i_right;
                end
            end
            OP_ROTATE: begin
                if (i_occ) begin
                    n_value = i_tail ? i_head : i_right;
                end
            end
            default: begin
                n_value = r_value;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule

// ===== rtl/core/sss_ctrl.sv =====
// Controller of the sorted set store: element count, listing sequencer
// and output register. Depends on sss_pkg.
module sss_ctrl
    import sss_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_word    i_in,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_word   o_out,
    input  t_chain_stat i_stat,
    output t_cell_cmd   o_cmd,
    output logic [CNT_W-1:0] o_count
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_LIST = 2'b10
    } t_state;

    t_state                      r_state, n_state;
    logic [CNT_W-1:0]            r_count, n_count;
    logic [CNT_W-1:0]            r_left, n_left;
    logic signed [ELEM_BITS-1:0] r_min, n_min;
    logic                        r_out_valid, n_out_valid;
    t_out_word                   r_out, n_out;

    logic out_free;
    logic in_acc;
    logic full;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != ST_IDLE) || !out_free;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign full       = (r_count == CNT_W'(CAPACITY));
    assign o_count    = r_count;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_left      = r_left;
        n_min       = r_min;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        o_cmd.op    = OP_HOLD;
        o_cmd.key   = ELEM_BITS'(i_in.elem);

        if (in_acc) begin
            n_out_valid        = 1'b1;
            n_out              = '0;
            n_out.last         = 1'b1;
            case (t_mode'(i_in.mode))
                MODE_ADD: begin
                    n_out.was_member = i_stat.member;
                    if (!i_stat.member) begin
                        if (full) begin
                            n_out.status = 1'b1;
                        end else begin
                            o_cmd.op = OP_INSERT;
                            n_count  = r_count + CNT_W'(1);
                        end
                    end
                end
                MODE_REMOVE: begin
                    n_out.was_member = i_stat.member;
                    if (i_stat.member) begin
                        o_cmd.op = OP_REMOVE;
                        n_count  = r_count - CNT_W'(1);
                    end
                end
                MODE_QUERY: begin
                    n_out.was_member = i_stat.member;
                end
                MODE_LIST: begin
                    if (r_count != '0) begin
                        // Results come from the sequencer, one per cycle while the output is not stalled.
                        n_out_valid = 1'b0;
                        n_state     = ST_LIST;
                        n_left      = r_count;
                        n_min       = i_stat.head;
                    end
                end
                default: begin
                    n_out = '0;
                end
            endcase
            n_out.count    = 5'(n_count);
            n_out.is_empty = (n_count == '0);
        end else if (r_state == ST_LIST && out_free) begin
            // The head cell is emitted and the occupied cells rotate by one,
            // so after count steps the chain is back in order.
            o_cmd.op           = OP_ROTATE;
            n_out_valid        = 1'b1;
            n_out              = '0;
            n_out.count        = 5'(r_count);
            n_out.listed_value = 32'(i_stat.head);
            n_out.last         = (r_left == CNT_W'(1));
            n_left             = r_left - CNT_W'(1);
            if (r_left == CNT_W'(1)) begin
                n_state = ST_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_left      <= n_left;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_min <= n_min;
        r_out <= n_out;
    end

    always_comb begin
        o_out = r_out;
        if (r_out.is_empty) begin
            o_out.smallest = '0;
        end else if (r_state == ST_LIST) begin
            o_out.smallest = 32'(r_min);
        end else begin
            o_out.smallest = 32'(i_stat.head);
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== rtl/core/sorted_set_store.sv =====
// Sorted set store: keeps up to CAPACITY distinct signed elements in
// ascending order in a chain of compare-and-shift cells. For add, remove
// and query every cell compares against the element in parallel, the chain
// shifts on the edge that takes the word and the result word is registered
// on that same edge. A listing of n stored elements holds the input off
// while the sequencer emits one result word per element as the chain
// rotates through its head cell. A listing of an empty set answers with a
// single word like the other modes. A stalled result word also holds the
// input off. A new word is taken as soon as the previous result register is
// free or is being taken.
module sorted_set_store
    import sss_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out
);

    t_cell_cmd                   w_cmd;
    t_chain_stat                 w_stat;
    logic [CNT_W-1:0]            w_count;
    logic signed [ELEM_BITS-1:0] w_value [CAPACITY];
    logic [CAPACITY-1:0]         w_lt;
    logic [CAPACITY-1:0]         w_eq;

    assign w_stat.member = |w_eq;
    assign w_stat.head   = w_value[0];

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            logic signed [ELEM_BITS-1:0] w_left;
            logic                        w_left_lt;
            logic signed [ELEM_BITS-1:0] w_right;

            if (gi == 0) begin : g_first
                // A virtual cell below everything sits left of the head.
                assign w_left    = w_value[gi];
                assign w_left_lt = 1'b1;
            end else begin : g_mid
                assign w_left    = w_value[gi-1];
                assign w_left_lt = w_lt[gi-1];
            end

            if (gi == CAPACITY - 1) begin : g_end
                assign w_right = w_value[gi];
            end else begin : g_inner
                assign w_right = w_value[gi+1];
            end

            sss_cell u_cell (
                .i_clk     (i_clk),
                .i_cmd     (w_cmd),
                .i_occ     (w_count > CNT_W'(gi)),
                .i_tail    (w_count == CNT_W'(gi + 1)),
                .i_left    (w_left),
                .i_left_lt (w_left_lt),
                .i_right   (w_right),
                .i_head    (w_value[0]),
                .o_value   (w_value[gi]),
                .o_lt      (w_lt[gi]),
                .o_eq      (w_eq[gi])
            );
        end
    endgenerate

    sss_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd),
        .o_count     (w_count)
    );

endmodule

// ===== rtl/core/sss_checker.sv =====
// Port-level checks of the sorted set store result words.
// Depends on sss_pkg; bound to sorted_set_store below.
module sss_checker
    import sss_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_word o_out
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("stalled result word changed");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out.is_empty == (o_out.count == 5'd0))
        else $error("empty flag disagrees with count");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out.count <= 5'(CAPACITY))
        else $error("count above capacity");

    a_small: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.is_empty |-> o_out.smallest == 32'sd0)
        else $error("smallest not zero on empty set");

    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.status |->
            !o_out.was_member && o_out.count == 5'(CAPACITY))
        else $error("rejected add while not full");

endmodule

bind sorted_set_store sss_checker u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out)
);

// ===== dv/sorted_set_store_checker.sv =====
`timescale 1ns / 100ps
// Checker for the sorted set store: keeps its own ordered copy of the set,
// predicts every result word and compares it with what the block returns.
// Depends on sss_pkg for the word types, the mode codes and the capacity.
module sorted_set_store_checker
    import sss_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_stall,
    input  t_in_word  i_in,
    input  logic      i_out_valid,
    input  logic      i_out_stall,
    input  t_out_word i_out,
    output int        o_fail_count,
    output int        o_pending,
    output int        o_checked,
    output int        o_list_words,
    output int        o_full_rejects
);

    logic signed [ELEM_BITS-1:0] set_cells [CAPACITY];
    int                          set_size;
    t_out_word                   expected_q [$];
    t_out_word                   want;
    int                          fail_count;
    int                          pending_count;
    int                          checked_count;
    int                          list_count;
    int                          reject_count;

    assign o_fail_count   = fail_count;
    assign o_pending      = pending_count;
    assign o_checked      = checked_count;
    assign o_list_words   = list_count;
    assign o_full_rejects = reject_count;

    // Every result word carries the set summary as it stands after the word.
    function automatic t_out_word summary_word(input logic member, input logic rejected,
                                               input logic signed [31:0] listed,
                                               input logic last_flag);
        t_out_word r;
        r.was_member   = member;
        r.count        = 5'(set_size);
        r.is_empty     = (set_size == 0);
        r.smallest     = (set_size == 0) ? '0 : set_cells[0];
        r.status       = rejected;
        r.listed_value = listed;
        r.last         = last_flag;
        return r;
    endfunction

    task automatic apply_word(input t_in_word w);
        int                  pos;
        int                  k;
        logic                hit;
        logic                rejected;
        logic signed [31:0]  v;
        v        = w.elem;
        rejected = 1'b0;
        pos      = 0;
        if (w.mode == MODE_LIST) begin
            // An empty set still answers with one closing word.
            if (set_size == 0) begin
                expected_q.push_back(summary_word(1'b0, 1'b0, '0, 1'b1));
                list_count++;
            end else begin
                for (k = 0; k < set_size; k++) begin
                    expected_q.push_back(summary_word(1'b0, 1'b0, set_cells[k],
                                                      k == set_size - 1));
                    list_count++;
                end
            end
        end else begin
            while (pos < set_size && set_cells[pos] < v)
                pos++;
            hit = (pos < set_size) && (set_cells[pos] == v);
            if (w.mode == MODE_ADD && !hit) begin
                if (set_size >= CAPACITY) begin
                    rejected = 1'b1;
                    reject_count++;
                end else begin
                    for (k = set_size; k > pos; k--)
                        set_cells[k] = set_cells[k-1];
                    set_cells[pos] = v;
                    set_size++;
                end
            end else if (w.mode == MODE_REMOVE && hit) begin
                for (k = pos; k < set_size - 1; k++)
                    set_cells[k] = set_cells[k+1];
                set_size--;
            end
            expected_q.push_back(summary_word(hit, rejected, '0, 1'b1));
        end
    endtask

    task automatic check_field(input string name, input logic signed [63:0] exp_val,
                               input logic signed [63:0] act_val);
        if (exp_val !== act_val) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_val, act_val);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            set_size = 0;
            expected_q.delete();
        end else begin
            // Results leave before the word taken on this edge can produce any.
            if (i_out_valid && !i_out_stall) begin
                if (expected_q.size() == 0) begin
                    $error("unexpected result word: count %0d, listed_value %0d",
                           i_out.count, i_out.listed_value);
                    fail_count++;
                end else begin
                    want = expected_q.pop_front();
                    check_field("was_member",   want.was_member,   i_out.was_member);
                    check_field("count",        want.count,        i_out.count);
                    check_field("is_empty",     want.is_empty,     i_out.is_empty);
                    check_field("smallest",     want.smallest,     i_out.smallest);
                    check_field("status",       want.status,       i_out.status);
                    check_field("listed_value", want.listed_value, i_out.listed_value);
                    check_field("last",         want.last,         i_out.last);
                    checked_count++;
                end
            end
            if (i_in_valid && !i_in_stall)
                apply_word(i_in);
        end
        pending_count = expected_q.size();
    end

endmodule

// ===== dv/sorted_set_store_tb.sv =====
`timescale 1ns / 100ps
// Testbench top for the sorted set store: clock, reset, bursty word stimulus
// and a varying output stall; the checker module does all prediction.
// Depends on sss_pkg, sorted_set_store and sorted_set_store_checker.
module sorted_set_store_tb
    import sss_pkg::*;
();

    localparam int                 CYCLE_LIMIT = 400000;
    localparam int                 PHASES      = 12;
    localparam int                 PHASE_WORDS = 40;
    localparam int                 POOL_SIZE   = 20;
    localparam logic signed [31:0] ELEM_MIN    = 32'sh8000_0000;
    localparam logic signed [31:0] ELEM_MAX    = 32'sh7fff_ffff;

    typedef enum int {
        STALL_NONE,
        STALL_COIN,
        STALL_PERIODIC,
        STALL_RUNS
    } t_stall_style;

    typedef enum int {
        PHASE_FILL,
        PHASE_DRAIN,
        PHASE_MIXED
    } t_phase_kind;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_word  i_in        = '0;
    logic      i_out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_word o_out;

    int fail_count;
    int pending_results;
    int results_checked;
    int list_words;
    int full_rejects;
    int words_sent;
    int cycle_count;

    t_in_word           stim_q [$];
    logic signed [31:0] elem_pool [POOL_SIZE];

    t_stall_style stall_style;
    int           style_left;
    int           run_left;
    int           stall_tick;

    sorted_set_store i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    sorted_set_store_checker i_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_in           (i_in),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_out          (o_out),
        .o_fail_count   (fail_count),
        .o_pending      (pending_results),
        .o_checked      (results_checked),
        .o_list_words   (list_words),
        .o_full_rejects (full_rejects)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // The receiver picks a new stall style at random when the current one runs out.
    always @(negedge i_clk) begin
        if (style_left == 0) begin
            stall_style = t_stall_style'($urandom_range(0, 3));
            style_left  = $urandom_range(20, 120);
        end
        style_left--;
        stall_tick++;
        case (stall_style)
            STALL_NONE:     i_out_stall <= 1'b0;
            STALL_COIN:     i_out_stall <= ($urandom_range(0, 1) == 1);
            STALL_PERIODIC: i_out_stall <= (stall_tick % 8 < 3);
            default: begin
                if (run_left == 0 && $urandom_range(0, 5) == 0)
                    run_left = $urandom_range(1, 8);
                i_out_stall <= (run_left > 0);
                if (run_left > 0)
                    run_left--;
            end
        endcase
    end

    task automatic queue_word(input t_mode m, input logic signed [31:0] v);
        t_in_word w;
        w.mode = m;
        w.elem = v;
        stim_q.push_back(w);
    endtask

    // Sends the queued words in bursts; a gap of zero keeps valid high.
    task automatic send_queue();
        int       burst;
        int       gap;
        t_in_word w;
        while (stim_q.size() > 0) begin
            burst = $urandom_range(1, 12);
            while (burst > 0 && stim_q.size() > 0) begin
                w = stim_q.pop_front();
                @(negedge i_clk);
                i_in       <= w;
                i_in_valid <= 1'b1;
                do
                    @(posedge i_clk);
                while (o_in_stall);
                words_sent++;
                burst--;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            repeat (gap) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
            end
        end
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_results != 0)
            @(negedge i_clk);
    endtask

    // A small pool makes adds and removes hit present elements often.
    task automatic refill_pool();
        int k;
        for (k = 0; k < POOL_SIZE; k++) begin
            case ($urandom_range(0, 4))
                0, 1:    elem_pool[k] = $urandom();
                2:       elem_pool[k] = $urandom_range(0, 20) - 10;
                3:       elem_pool[k] = ELEM_MIN + $urandom_range(0, 3);
                default: elem_pool[k] = ELEM_MAX - $urandom_range(0, 3);
            endcase
        end
    endtask

    function automatic t_in_word random_word(input t_phase_kind kind);
        t_in_word w;
        int       r;
        int       add_pct;
        int       rem_pct;
        case (kind)
            PHASE_FILL:  begin add_pct = 65; rem_pct = 10; end
            PHASE_DRAIN: begin add_pct = 10; rem_pct = 65; end
            default:     begin add_pct = 35; rem_pct = 30; end
        endcase
        r = $urandom_range(0, 99);
        if (r < add_pct)
            w.mode = MODE_ADD;
        else if (r < add_pct + rem_pct)
            w.mode = MODE_REMOVE;
        else if (r < 90)
            w.mode = MODE_QUERY;
        else
            w.mode = MODE_LIST;
        if ($urandom_range(0, 9) == 0)
            w.elem = $urandom();
        else
            w.elem = elem_pool[$urandom_range(0, POOL_SIZE - 1)];
        return w;
    endfunction

    initial begin
        int phase;
        int n;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Empty set: listing, query and remove of an absent element.
        queue_word(MODE_LIST, 32'sd77);
        queue_word(MODE_QUERY, 32'sd5);
        queue_word(MODE_REMOVE, 32'sd5);
        queue_word(MODE_ADD, ELEM_MIN);
        queue_word(MODE_ADD, ELEM_MAX);
        queue_word(MODE_ADD, 32'sd0);
        queue_word(MODE_ADD, -32'sd1);
        queue_word(MODE_ADD, 32'sd1);
        queue_word(MODE_ADD, ELEM_MAX);
        queue_word(MODE_REMOVE, 32'sd0);
        queue_word(MODE_REMOVE, 32'sd0);
        for (n = 0; n < CAPACITY - 4; n++)
            queue_word(MODE_ADD, 7 * (n + 1) - 40);
        // Full set: an absent element is turned away, a present one is not.
        queue_word(MODE_ADD, 32'sd100);
        queue_word(MODE_ADD, ELEM_MAX);
        queue_word(MODE_LIST, ELEM_MIN);
        send_queue();
        wait_drained();

        for (phase = 0; phase < PHASES; phase++) begin
            refill_pool();
            for (n = 0; n < PHASE_WORDS; n++)
                stim_q.push_back(random_word(t_phase_kind'(phase % 3)));
            send_queue();
            if (phase % 4 == 3)
                wait_drained();
        end

        wait_drained();
        repeat (20) @(posedge i_clk);
        $display("Sent %0d words; checked %0d result words, %0d of them from listings.",
                 words_sent, results_checked, list_words);
        $display("Adds turned away on a full set: %0d; mismatches: %0d.",
                 full_rejects, fail_count);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== sorted_set_store.f =====
rtl/core/sss_pkg.sv
rtl/core/sss_cell.sv
rtl/core/sss_ctrl.sv
rtl/core/sorted_set_store.sv
rtl/core/sss_checker.sv
dv/sorted_set_store_checker.sv
dv/sorted_set_store_tb.sv
